// ===== rtl/aba_pkg.sv =====
// Shared constants, types and helper functions of the alpha blend blitter.
package aba_pkg;

    // Frame store geometry
    localparam int MAX_W    = 256;
    localparam int MAX_H    = 256;
    localparam int FS_DEPTH = MAX_W * MAX_H;
    localparam int FS_AW    = $clog2(FS_DEPTH);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int ADDR_W = 16;
    localparam int WORD_W = 32;
    localparam int POS_W  = 8;
    localparam int DIM_W  = 9;

    // Raster position and target coordinate widths
    localparam int COL_W     = $clog2(MAX_W);
    localparam int ROW_W     = $clog2(MAX_H);
    localparam int X_W       = ((POS_W > COL_W) ? POS_W : COL_W) + 1;
    localparam int Y_W       = ((POS_W > ROW_W) ? POS_W : ROW_W) + 1;
    localparam int X_CMP_W   = (X_W > DIM_W) ? X_W : DIM_W;
    localparam int Y_CMP_W   = (Y_W > DIM_W) ? Y_W : DIM_W;
    localparam int COL_CMP_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int ROW_CMP_W = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;

    // Op queue between front and back (power of two)
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Configuration registers
    localparam int NUM_REGS = 6;
    localparam int PADDR_W  = $clog2(NUM_REGS * 4);
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DEST_X     = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_DEST_Y     = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_BUF_WIDTH  = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_BUF_HEIGHT = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = REG_IDX_W'(5);

    localparam logic [DIM_W-1:0] RST_BUF_DIM = DIM_W'(256);
    localparam logic [DIM_W-1:0] RST_SRC_DIM = DIM_W'(1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BLEND = 2'd2;

    localparam logic [7:0] ALPHA_MAX = 8'd255;

    // What the back end does with an op
    typedef enum logic [1:0] {
        KIND_LOAD,   // write data, report it
        KIND_ECHO,   // no store access, report data field
        KIND_READ,   // report the stored word
        KIND_BLEND   // blend data over stored word, write back
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [FS_AW-1:0]  mem_addr;
        logic [ADDR_W-1:0] out_addr;
        logic [WORD_W-1:0] data;
        logic              last;
    } t_op;

    typedef struct packed {
        logic [POS_W-1:0] dest_x;
        logic [POS_W-1:0] dest_y;
        logic [DIM_W-1:0] buf_width;
        logic [DIM_W-1:0] buf_height;
        logic [DIM_W-1:0] src_width;
        logic [DIM_W-1:0] src_height;
    } t_cfg;

    typedef struct packed {
        logic            full;
        logic [Q_CW-1:0] count;
    } t_q_stat;

    // Zero counts as one, anything above the limit counts as the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int lim);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > lim) begin
            r = DIM_W'(lim);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Per channel (a*src + (255-a)*dst) >> 8, alpha taken from src.
    function automatic logic [WORD_W-1:0] blend_word(input logic [WORD_W-1:0] src,
                                                     input logic [WORD_W-1:0] dst);
        logic [7:0]        a;
        logic [7:0]        inv;
        logic [15:0]       ps;
        logic [15:0]       pd;
        logic [15:0]       acc;
        logic [WORD_W-1:0] res;
        a   = src[31:24];
        inv = ALPHA_MAX - a;
        res = {a, 24'h0};
        for (int c = 0; c < 3; c++) begin
            ps  = a * src[8*c +: 8];
            pd  = inv * dst[8*c +: 8];
            acc = ps + pd;
            res[8*c +: 8] = acc[15:8];
        end
        return res;
    endfunction

endpackage

// ===== rtl/aba_if.sv =====
// Valid/ready stream interfaces for command words and result words.
interface aba_in_if import aba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;

    modport source (output valid, cmd, addr, data, input ready);
    modport sink   (input valid, cmd, addr, data, output ready);
endinterface

interface aba_out_if import aba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] rdata;
    logic              wrote;
    logic [ADDR_W-1:0] out_addr;
    logic              last_pixel;

    modport source (output valid, rdata, wrote, out_addr, last_pixel, input ready);
    modport sink   (input valid, rdata, wrote, out_addr, last_pixel, output ready);
endinterface

// ===== rtl/alpha_blend_blitter.sv =====
// Alpha blend blitter top: APB registers, front end, op queue, back end.
// Path: op queue, execute stage, result register. Throughput: one word per
// cycle while o_out.ready holds; the frame store has one read and
// one write port, and a write bypass covers back-to-back hits on one pixel.
// Reset: registers to defaults, raster position to (0,0), pipeline emptied;
// the frame store is not cleared and holds garbage until written.
module alpha_blend_blitter import aba_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    aba_in_if.sink             i_in,
    aba_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int INFL_W   = $clog2(Q_DEPTH + 3);
    localparam int INFL_MAX = Q_DEPTH + 2;   // queue plus execute stage plus result reg

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_cfg                 r_cfg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_x     <= '0;
            r_cfg.dest_y     <= '0;
            r_cfg.buf_width  <= RST_BUF_DIM;
            r_cfg.buf_height <= RST_BUF_DIM;
            r_cfg.src_width  <= RST_SRC_DIM;
            r_cfg.src_height <= RST_SRC_DIM;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DEST_X:     r_cfg.dest_x     <= pwdata[POS_W-1:0];
                REG_DEST_Y:     r_cfg.dest_y     <= pwdata[POS_W-1:0];
                REG_BUF_WIDTH:  r_cfg.buf_width  <= pwdata[DIM_W-1:0];
                REG_BUF_HEIGHT: r_cfg.buf_height <= pwdata[DIM_W-1:0];
                REG_SRC_WIDTH:  r_cfg.src_width  <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= pwdata[DIM_W-1:0];
                default:        r_cfg            <= r_cfg;   // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEST_X:     prdata = 32'(r_cfg.dest_x);
            REG_DEST_Y:     prdata = 32'(r_cfg.dest_y);
            REG_BUF_WIDTH:  prdata = 32'(r_cfg.buf_width);
            REG_BUF_HEIGHT: prdata = 32'(r_cfg.buf_height);
            REG_SRC_WIDTH:  prdata = 32'(r_cfg.src_width);
            REG_SRC_HEIGHT: prdata = 32'(r_cfg.src_height);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath: front classifies, queue buffers, back does the RMW
    // ------------------------------------------------------------------
    logic    q_push;
    t_op     q_op;
    logic    q_pop;
    logic    q_head_valid;
    t_op     q_head;
    t_q_stat q_stat;

    aba_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_op     (q_op)
    );

    aba_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_op         (q_op),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head),
        .o_stat       (q_stat)
    );

    aba_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out        (o_out)
    );

    // ------------------------------------------------------------------
    // Checks: words in flight (accepted, result not yet taken)
    // ------------------------------------------------------------------
    logic [INFL_W-1:0] r_inflight;
    logic              in_fire, out_fire;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + INFL_W'(in_fire) - INFL_W'(out_fire);
        end
    end

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= INFL_W'(INFL_MAX))
        else $error("more words in flight than the pipeline can hold");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_inflight != '0))
        else $error("result presented with no word in flight");

    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        INFL_W'(q_stat.count) <= r_inflight)
        else $error("op queue holds more than the words in flight");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> i_in.ready)
        else $error("input stalled with the pipeline empty");

endmodule

// ===== rtl/aba_front.sv =====
// Front end: accepts command words, tracks raster position, clips and classifies.
module aba_front import aba_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    aba_in_if.sink       i_in,
    input  t_q_stat      i_q_stat,
    output logic         o_push,
    output t_op          o_op
);

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [DIM_W-1:0] bw, bh, sw, sh;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [FS_AW-1:0] idx;
    logic             in_box;
    logic             col_wrap, row_wrap;
    logic             fire;

    assign i_in.ready = !i_q_stat.full;
    assign fire       = i_in.valid && i_in.ready;
    assign o_push     = fire;

    always_comb begin
        bw = clamp_dim(i_cfg.buf_width, MAX_W);
        bh = clamp_dim(i_cfg.buf_height, MAX_H);
        sw = clamp_dim(i_cfg.src_width, MAX_W);
        sh = clamp_dim(i_cfg.src_height, MAX_H);
        x  = X_W'(i_cfg.dest_x) + X_W'(r_col);
        y  = Y_W'(i_cfg.dest_y) + Y_W'(r_row);
        in_box = (X_CMP_W'(x) < X_CMP_W'(bw)) && (Y_CMP_W'(y) < Y_CMP_W'(bh));
        idx = FS_AW'(FS_AW'(y) * FS_AW'(bw)) + FS_AW'(x);
        col_wrap = (COL_CMP_W'(r_col) + COL_CMP_W'(1)) >= COL_CMP_W'(sw);
        row_wrap = (ROW_CMP_W'(r_row) + ROW_CMP_W'(1)) >= ROW_CMP_W'(sh);

        // raster step: column first, row on column wrap
        n_col = col_wrap ? '0 : r_col + COL_W'(1);
        n_row = r_row;
        if (col_wrap) begin
            n_row = row_wrap ? '0 : r_row + ROW_W'(1);
        end
    end

    always_comb begin
        o_op = '{kind: KIND_ECHO, mem_addr: '0, out_addr: '0, data: '0, last: 1'b0};
        case (i_in.cmd)
            CMD_LOAD: begin
                o_op.mem_addr = FS_AW'(i_in.addr);
                o_op.out_addr = i_in.addr;
                o_op.data     = i_in.data;
                o_op.kind     = (int'(i_in.addr) < FS_DEPTH) ? KIND_LOAD : KIND_ECHO;
            end
            CMD_READ: begin
                o_op.mem_addr = FS_AW'(i_in.addr);
                o_op.out_addr = i_in.addr;
                o_op.kind     = (int'(i_in.addr) < FS_DEPTH) ? KIND_READ : KIND_ECHO;
            end
            CMD_BLEND: begin
                o_op.last = col_wrap && row_wrap;
                if (in_box) begin
                    o_op.mem_addr = idx;
                    o_op.out_addr = ADDR_W'(idx);
                    o_op.data     = i_in.data;
                    // fully transparent source only reads back the target
                    o_op.kind     = (i_in.data[31:24] != 8'h0) ? KIND_BLEND : KIND_READ;
                end
            end
            default: begin
                o_op.kind = KIND_ECHO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (fire && (i_in.cmd == CMD_BLEND)) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== rtl/aba_queue.sv =====
// Small op queue decoupling the front end from the back end.
module aba_queue import aba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_op      i_op,
    input  logic     i_pop,
    output logic     o_head_valid,
    output t_op      o_head,
    output t_q_stat  o_stat
);

    t_op             r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rp];
    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.count = r_count;

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/aba_back.sv =====
// Back end: frame store, read-modify-write with write bypass, result register.
module aba_back import aba_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_op       i_head,
    output logic      o_pop,
    aba_out_if.source o_out
);

    logic [WORD_W-1:0] r_frame_store [FS_DEPTH];

    // execute stage
    logic              r_b_valid;
    t_op               r_b_op;
    logic [WORD_W-1:0] r_rd_q;
    logic              r_fwd_hit;
    logic [WORD_W-1:0] r_fwd_data;

    // result register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_rdata;
    logic              r_out_wrote;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_last;

    logic              out_can, b_adv, we;
    logic [WORD_W-1:0] dst;
    logic [WORD_W-1:0] res_rdata;
    logic              res_wrote;

    assign out_can = !r_out_valid || o_out.ready;
    assign b_adv   = r_b_valid && out_can;
    assign o_pop   = i_head_valid && (!r_b_valid || b_adv);
    assign we      = b_adv && res_wrote;

    // a write retiring on the same edge as the read is not seen by the read
    assign dst = r_fwd_hit ? r_fwd_data : r_rd_q;

    always_comb begin
        case (r_b_op.kind)
            KIND_LOAD: begin
                res_rdata = r_b_op.data;
                res_wrote = 1'b1;
            end
            KIND_READ: begin
                res_rdata = dst;
                res_wrote = 1'b0;
            end
            KIND_BLEND: begin
                res_rdata = blend_word(r_b_op.data, dst);
                res_wrote = 1'b1;
            end
            default: begin
                res_rdata = r_b_op.data;
                res_wrote = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_frame_store[r_b_op.mem_addr] <= res_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_q <= r_frame_store[i_head.mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_op     <= i_head;
            r_fwd_hit  <= we && (r_b_op.mem_addr == i_head.mem_addr);
            r_fwd_data <= res_rdata;
        end
        if (b_adv) begin
            r_out_rdata <= res_rdata;
            r_out_wrote <= res_wrote;
            r_out_addr  <= r_b_op.out_addr;
            r_out_last  <= r_b_op.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (out_can) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.rdata      = r_out_rdata;
    assign o_out.wrote      = r_out_wrote;
    assign o_out.out_addr   = r_out_addr;
    assign o_out.last_pixel = r_out_last;

endmodule
